@@ rtl/ctc_pkg.sv @@
// Package for the compare timer/counter: command and register codes, the
// queued operation word, and prescaler helpers. No dependencies.
package ctc_pkg;

  localparam int unsigned CHANNELS = 3;
  localparam logic [2:0] CH_MASK = 3'((1 << CHANNELS) - 1);
  localparam logic [2:0] PRESCALE_COUNT = 3'd5;
  localparam int unsigned CTC_BIT = 3;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_CTRL  = 3'd0,
    REG_COUNT = 3'd1,
    REG_CMP_A = 3'd2,
    REG_CMP_B = 3'd3,
    REG_CMP_C = 3'd4,
    REG_FLAGS = 3'd5,
    REG_MASK  = 3'd6,
    REG_NONE  = 3'd7
  } reg_e;

  typedef struct packed {
    cmd_e        cmd;
    reg_e        addr;
    logic [15:0] wdata;
    logic        bad;
  } op_t;

  function automatic logic [3:0] prescale_shift(input logic [2:0] sel);
    logic [3:0] sh;
    unique case (sel)
      3'd1:    sh = 4'd0;
      3'd2:    sh = 4'd3;
      3'd3:    sh = 4'd6;
      3'd4:    sh = 4'd8;
      3'd5:    sh = 4'd10;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [9:0] prescale_limit(input logic [2:0] sel);
    logic [10:0] one;
    one = 11'd1 << prescale_shift(sel);
    return 10'(one - 11'd1);
  endfunction

  function automatic logic addr_used(input logic [2:0] addr);
    logic ok;
    if (addr >= 3'(REG_CMP_A) && addr <= 3'(REG_CMP_C)) begin
      ok = (32'(addr - 3'(REG_CMP_A)) < CHANNELS);
    end else begin
      ok = (addr != 3'(REG_NONE));
    end
    return ok;
  endfunction

endpackage

@@ rtl/ctc_if.sv @@
// Valid/ready channel interfaces for the compare timer/counter.
// Depends on nothing; used by ctc_front, ctc_back and the top level.
interface ctc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  reg_addr;
  logic [15:0] wdata;
  modport source (output valid, output cmd, output reg_addr, output wdata, input ready);
  modport sink (input valid, input cmd, input reg_addr, input wdata, output ready);
endinterface

interface ctc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rdata;
  logic [2:0]  irq_pending;
  logic        bad_access;
  modport source (output valid, output rdata, output irq_pending, output bad_access,
                  input ready);
  modport sink (input valid, input rdata, input irq_pending, input bad_access,
                output ready);
endinterface

@@ rtl/ctc_front.sv @@
// Front end: accepts input words and classifies them into queued operations.
// Depends on ctc_pkg and ctc_in_if.
module ctc_front (
  ctc_in_if.sink      in_i,
  input  logic        full_i,
  output logic        push_o,
  output ctc_pkg::op_t op_o
);

  ctc_pkg::cmd_e cmd;

  assign cmd = ctc_pkg::cmd_e'(in_i.cmd);
  assign in_i.ready = !full_i;
  assign push_o = in_i.valid && !full_i;

  always_comb begin
    op_o.addr  = ctc_pkg::reg_e'(in_i.reg_addr);
    op_o.wdata = in_i.wdata;
    op_o.cmd   = cmd;
    op_o.bad   = 1'b0;
    unique case (cmd)
      ctc_pkg::CMD_WRITE, ctc_pkg::CMD_READ: begin
        if (!ctc_pkg::addr_used(in_i.reg_addr)) begin
          op_o.cmd = ctc_pkg::CMD_NONE;
          op_o.bad = 1'b1;
        end
      end
      ctc_pkg::CMD_TICK, ctc_pkg::CMD_NONE: begin
      end
    endcase
  end

endmodule

@@ rtl/ctc_queue.sv @@
// Two-entry operation queue between the front end and the execute stage.
// Depends on ctc_pkg.
module ctc_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ctc_pkg::op_t op_i,
  output logic         full_o,
  output logic         valid_o,
  output ctc_pkg::op_t op_o,
  input  logic         pop_i
);

  ctc_pkg::op_t mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

@@ rtl/ctc_back.sv @@
// Execute stage: timer state, prescaler, compare channels and bus registers,
// with a registered result word. Depends on ctc_pkg and ctc_out_if.
module ctc_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  ctc_pkg::op_t op_i,
  output logic         pop_o,
  ctc_out_if.source    out_o
);

  logic [15:0] count_q, count_d;
  logic [9:0]  div_q, div_d;
  logic [2:0]  sel_q, sel_d;
  logic        com_q, com_d;
  logic [15:0] cmp_q [3];
  logic [15:0] cmp_d [3];
  logic [2:0]  flags_q, flags_d;
  logic [2:0]  mask_q, mask_d;
  logic [9:0]  limit;
  logic [1:0]  cmp_idx;
  logic [15:0] rdata;

  logic        out_valid_q, out_valid_d;
  logic [15:0] rdata_q;
  logic [2:0]  irq_q;
  logic        bad_q;

  assign pop_o   = valid_i && (!out_valid_q || out_o.ready);
  assign limit   = ctc_pkg::prescale_limit(sel_q);
  assign cmp_idx = 2'(op_i.addr - ctc_pkg::REG_CMP_A);

  always_comb begin
    count_d = count_q;
    div_d   = div_q;
    sel_d   = sel_q;
    com_d   = com_q;
    cmp_d   = cmp_q;
    flags_d = flags_q;
    mask_d  = mask_q;
    rdata   = 16'd0;
    if (pop_o) begin
      unique case (op_i.cmd)
        ctc_pkg::CMD_TICK: begin
          if (sel_q != 3'd0 && sel_q <= ctc_pkg::PRESCALE_COUNT) begin
            if (div_q < limit) begin
              div_d = div_q + 10'd1;
            end else begin
              div_d = 10'd0;
              for (int ch = 0; ch < ctc_pkg::CHANNELS; ch++) begin
                if (cmp_q[ch] == count_q) begin
                  flags_d[ch] = 1'b1;
                end
              end
              if (com_q && count_q == cmp_q[0]) begin
                count_d = 16'd0;
              end else begin
                count_d = count_q + 16'd1;
              end
            end
          end
        end
        ctc_pkg::CMD_WRITE: begin
          unique case (op_i.addr)
            ctc_pkg::REG_CTRL: begin
              sel_d = op_i.wdata[2:0];
              com_d = op_i.wdata[ctc_pkg::CTC_BIT];
            end
            ctc_pkg::REG_COUNT: count_d = op_i.wdata;
            ctc_pkg::REG_CMP_A, ctc_pkg::REG_CMP_B, ctc_pkg::REG_CMP_C: begin
              for (int i = 0; i < 3; i++) begin
                if (cmp_idx == 2'(i)) begin
                  cmp_d[i] = op_i.wdata;
                end
              end
            end
            ctc_pkg::REG_FLAGS: flags_d = flags_q & ~op_i.wdata[2:0] & ctc_pkg::CH_MASK;
            ctc_pkg::REG_MASK:  mask_d  = op_i.wdata[2:0] & ctc_pkg::CH_MASK;
            ctc_pkg::REG_NONE: begin
            end
          endcase
        end
        ctc_pkg::CMD_READ: begin
          unique case (op_i.addr)
            ctc_pkg::REG_CTRL:  rdata = {12'd0, com_q, sel_q};
            ctc_pkg::REG_COUNT: rdata = count_q;
            ctc_pkg::REG_CMP_A: rdata = cmp_q[0];
            ctc_pkg::REG_CMP_B: rdata = cmp_q[1];
            ctc_pkg::REG_CMP_C: rdata = cmp_q[2];
            ctc_pkg::REG_FLAGS: rdata = {13'd0, flags_q & ctc_pkg::CH_MASK};
            ctc_pkg::REG_MASK:  rdata = {13'd0, mask_q & ctc_pkg::CH_MASK};
            ctc_pkg::REG_NONE:  rdata = 16'd0;
          endcase
        end
        ctc_pkg::CMD_NONE: begin
        end
      endcase
    end
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 16'd0;
      div_q       <= 10'd0;
      sel_q       <= 3'd0;
      com_q       <= 1'b0;
      cmp_q       <= '{default: 16'd0};
      flags_q     <= 3'd0;
      mask_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      div_q       <= div_d;
      sel_q       <= sel_d;
      com_q       <= com_d;
      cmp_q       <= cmp_d;
      flags_q     <= flags_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rdata_q <= rdata;
      irq_q   <= flags_d & mask_d & ctc_pkg::CH_MASK;
      bad_q   <= op_i.bad;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.rdata       = rdata_q;
  assign out_o.irq_pending = irq_q;
  assign out_o.bad_access  = bad_q;

endmodule

@@ rtl/timer_counter_compare_ctc.sv @@
// Top level of the 16-bit compare timer/counter with clear-on-compare mode.
// Depends on ctc_pkg, ctc_in_if/ctc_out_if, ctc_front, ctc_queue, ctc_back.
//
// in_i carries one word per core-clock tick, bus write or bus read; out_o
// returns exactly one word per input word, in order, with read data, the
// enabled pending compare flags and an unused-address marker.
// An accepted word is written into the queue, executed at the queue head and
// its result registered (valid high from then on until taken); out_o takes it
// from that register. Throughput: one word per cycle while out_o does not
// stall, set by the execute stage that updates counter, prescaler and flags.
// A two-word queue separates the front end from the execute stage; a
// registered result word separates the execute stage from the receiver.
// While out_o stalls, the queue fills and in_i.ready drops once it holds two
// words; nothing is dropped.
// Reset (rst_ni low, asynchronous) stops the timer, clears counter,
// prescaler, compare values, flags and mask, and empties queue and output.
module timer_counter_compare_ctc (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctc_in_if.sink    in_i,
  ctc_out_if.source out_o
);

  logic         push;
  logic         full;
  logic         q_valid;
  logic         pop;
  ctc_pkg::op_t push_op;
  ctc_pkg::op_t head_op;

  ctc_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .op_o   (push_op)
  );

  ctc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .valid_o (q_valid),
    .op_o    (head_op),
    .pop_i   (pop)
  );

  ctc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .op_i    (head_op),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
